/* rtl/u2u16_pkg.sv */
// shared types and constants for the utf-8 to utf-16le transcoder
package u2u16_pkg;

  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;
  localparam int          MAX_UNITS   = 4;

  localparam logic [2:0]  SEQ_NONE    = 3'd0;
  localparam logic [2:0]  SEQ_TWO     = 3'd2;
  localparam logic [2:0]  SEQ_THREE   = 3'd3;
  localparam logic [2:0]  SEQ_FOUR    = 3'd4;

  typedef logic [MAX_UNITS-1:0][15:0] unit_vec_t;

  // decoded result of one input byte: up to four utf-16 units
  typedef struct packed {
    unit_vec_t  units;
    logic [2:0] num_units;   // 0 to 4
  } dec_result_t;

endpackage

/* rtl/u2u16_decode.sv */
// sequence state and per-byte decode into utf-16 units
module u2u16_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  take,
  output u2u16_pkg::dec_result_t result
);

  logic [2:0]  seq_len, seq_len_next;
  logic [1:0]  taken, taken_next;
  logic [20:0] cp, cp_next;

  logic        is_cont;
  logic        open_seq;
  logic [20:0] cp_cont;
  logic [1:0]  taken_cont;
  logic        complete;
  logic [20:0] supp;
  logic [1:0]  prefix;
  logic        lead_unit;
  logic [15:0] lead_val;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;

  always_comb begin
    is_cont    = (in_byte[7:6] == 2'b10);
    open_seq   = (seq_len != u2u16_pkg::SEQ_NONE);
    cp_cont    = {cp[14:0], in_byte[5:0]};
    taken_cont = taken + 2'd1;
    complete   = ({1'b0, taken_cont} == seq_len) ||
                 (seq_len == u2u16_pkg::SEQ_FOUR && taken_cont == 2'd0);
    supp       = cp_cont - u2u16_pkg::SUPP_BASE;

    // lead byte classification
    lead_len  = u2u16_pkg::SEQ_NONE;
    lead_bits = '0;
    if (in_byte[7:5] == 3'b110) begin
      lead_len  = u2u16_pkg::SEQ_TWO;
      lead_bits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_len  = u2u16_pkg::SEQ_THREE;
      lead_bits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_len  = u2u16_pkg::SEQ_FOUR;
      lead_bits = {18'd0, in_byte[2:0]};
    end

    seq_len_next = seq_len;
    taken_next   = taken;
    cp_next      = cp;
    result.units     = '0;
    result.num_units = 3'd0;
    prefix    = 2'd0;
    lead_unit = 1'b0;
    lead_val  = u2u16_pkg::REPL_CHAR;

    if (open_seq && is_cont) begin
      if (complete) begin
        seq_len_next = u2u16_pkg::SEQ_NONE;
        taken_next   = 2'd0;
        cp_next      = '0;
        if (cp_cont >= u2u16_pkg::SUPP_BASE) begin
          result.units[0]  = u2u16_pkg::HI_SURR | {5'd0, supp[20:10]};
          result.units[1]  = u2u16_pkg::LO_SURR | {6'd0, supp[9:0]};
          result.num_units = 3'd2;
        end else begin
          result.units[0]  = cp_cont[15:0];
          result.num_units = 3'd1;
        end
      end else if (in_last) begin
        // cut off by end of string: one replacement per byte taken
        seq_len_next = u2u16_pkg::SEQ_NONE;
        taken_next   = 2'd0;
        cp_next      = '0;
        for (int i = 0; i < u2u16_pkg::MAX_UNITS; i++) begin
          result.units[i] = u2u16_pkg::REPL_CHAR;
        end
        result.num_units = {1'b0, taken_cont};
      end else begin
        taken_next = taken_cont;
        cp_next    = cp_cont;
      end
    end else begin
      // no open sequence, or a bad continuation that flushes it: the byte is handled as a lead
      if (open_seq) begin
        prefix = taken;
      end
      seq_len_next = u2u16_pkg::SEQ_NONE;
      taken_next   = 2'd0;
      cp_next      = '0;
      if (!in_byte[7]) begin
        lead_unit = 1'b1;
        lead_val  = {8'd0, in_byte};
      end else if (lead_len == u2u16_pkg::SEQ_NONE || in_last) begin
        lead_unit = 1'b1;
      end else begin
        seq_len_next = lead_len;
        taken_next   = 2'd1;
        cp_next      = lead_bits;
      end
      for (int i = 0; i < u2u16_pkg::MAX_UNITS; i++) begin
        result.units[i] = (i < int'(prefix)) ? u2u16_pkg::REPL_CHAR : lead_val;
      end
      result.num_units = {1'b0, prefix} + {2'd0, lead_unit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= u2u16_pkg::SEQ_NONE;
      taken   <= 2'd0;
      cp      <= '0;
    end else if (take) begin
      seq_len <= seq_len_next;
      taken   <= taken_next;
      cp      <= cp_next;
    end
  end

endmodule

/* rtl/u2u16_out.sv */
// result register and byte serializer, low byte of each unit first
module u2u16_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  u2u16_pkg::dec_result_t result,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast
);

  u2u16_pkg::unit_vec_t units;
  logic [2:0] last_idx;
  logic [2:0] idx;
  logic       busy;
  logic       advance;
  logic       done_now;
  logic [2:0] load_last;

  always_comb begin
    advance   = busy && m_tready;
    done_now  = advance && (idx == last_idx);
    free      = !busy || done_now;
    load_last = {result.num_units[1:0] - 2'd1, 1'b1};
    m_tvalid  = busy;
    m_tlast   = (idx == last_idx);
    m_tdata   = idx[0] ? units[idx[2:1]][15:8] : units[idx[2:1]][7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done_now) begin
      busy <= 1'b0;
    end else if (advance) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units    <= result.units;
      last_idx <= load_last;
    end
  end

endmodule

/* rtl/utf8_to_utf16le_transcoder_core.sv */
// top level of the utf-8 to utf-16le transcoder
// path: a byte is captured in the input register, decoded combinationally and loaded into
//   the result register when that is free, which drives the output beats directly
// throughput: one output beat per cycle while m_tready is high; a byte causes up to eight
//   output bytes, and a byte causing none leaves the input register without waiting
// reset: synchronous active-high rst closes any open sequence and empties both registers
module utf8_to_utf16le_transcoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast    // out_last
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  u2u16_pkg::dec_result_t result;
  logic out_free;
  logic has_units;
  logic take;

  // a byte leaves the input register when its units fit into the result register,
  // or right away when it yields nothing (lead or middle of an unfinished sequence)
  always_comb begin
    has_units = (result.num_units != 3'd0);
    take      = in_valid && (!has_units || out_free);
    s_tready  = !in_valid || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // decode against the open sequence state
  u2u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .in_last (in_last),
    .take    (take),
    .result  (result)
  );

  // result register and byte serializer
  u2u16_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && has_units),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/sv/utf8_to_utf16le_transcoder_core_test.sv */
// self-checking testbench for the utf-8 to utf-16le transcoder core
`timescale 1ns / 1ps

module utf8_to_utf16le_transcoder_core_test;

  localparam int RAND_ITEMS  = 410;
  localparam int HOLD_CYCLES = 320;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 12;

  // one utf-16le output beat as the sink should see it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf16_beat_t;

  // directed row: byte, last flag, units typed in by hand (0 = use the decoder), two units
  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic [1:0]  typed_n;
    logic [15:0] u0;
    logic [15:0] u1;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // in_byte[7:0]
  logic       s_tlast;   // in_last
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // out_byte[7:0]
  logic       m_tlast;   // out_last

  utf8_to_utf16le_transcoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state mirrored from the block
  logic [2:0]  open_len = u2u16_pkg::SEQ_NONE;
  logic [1:0]  taken_cnt = 2'd0;
  logic [20:0] cp_acc = 21'd0;

  utf16_beat_t utf16_beats_q[$];

  int  mismatch_cnt = 0;
  int  beats_seen = 0;
  int  dir_sent = 0;
  int  rand_sent = 0;
  int  strings_sent = 0;
  int  holds_done = 0;
  int  next_hold_at = 250;
  int  quiet_cycles = 0;
  bit  stim_done = 1'b0;

  stim_row_t dir_rows [26] = '{
    {8'h00, 1'b0, 2'd1, 16'h0000, 16'h0000},    // first byte after reset, lowest ascii
    {8'h7F, 1'b0, 2'd1, 16'h007F, 16'h0000},    // highest ascii
    {8'h80, 1'b0, 2'd1, u2u16_pkg::REPL_CHAR, 16'h0000},   // stray continuation as lead
    {8'hFF, 1'b0, 2'd1, u2u16_pkg::REPL_CHAR, 16'h0000},   // invalid lead
    {8'hC2, 1'b1, 2'd1, u2u16_pkg::REPL_CHAR, 16'h0000},   // lead cut off by end of string
    {8'hC3, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hA9, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hE2, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h82, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hAC, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000},    // surrogate pair
    {8'h9F, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h98, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hF7, 1'b0, 2'd0, 16'h0000, 16'h0000},    // largest 21-bit value
    {8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hBF, 1'b1, 2'd0, 16'h0000, 16'h0000},
    {8'hE2, 1'b0, 2'd0, 16'h0000, 16'h0000},    // bad continuation after a lead
    {8'h41, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000},    // bad continuation after three bytes
    {8'h9F, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h98, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'h41, 1'b0, 2'd0, 16'h0000, 16'h0000},
    {8'hE2, 1'b0, 2'd0, 16'h0000, 16'h0000},    // continuation cut off by end of string
    {8'h82, 1'b1, 2'd2, u2u16_pkg::REPL_CHAR, u2u16_pkg::REPL_CHAR}
  };

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // utf-16 units produced by one utf-8 byte, advancing the mirrored state
  task automatic decode_byte(input logic [7:0] b, input logic l,
                             output u2u16_pkg::unit_vec_t units, output int n);
    logic [2:0]  len;
    logic [20:0] bits;
    logic [20:0] v;
    bit          done;
    units = '0;
    n = 0;
    done = 1'b0;
    if (open_len != u2u16_pkg::SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        taken_cnt = taken_cnt + 2'd1;
        if ({1'b0, taken_cnt} == open_len ||
            (open_len == u2u16_pkg::SEQ_FOUR && taken_cnt == 2'd0)) begin
          if (cp_acc >= u2u16_pkg::SUPP_BASE) begin
            v = cp_acc - u2u16_pkg::SUPP_BASE;
            units[n] = u2u16_pkg::HI_SURR | {5'b0, v[20:10]};
            units[n + 1] = u2u16_pkg::LO_SURR | {6'b0, v[9:0]};
            n = n + 2;
          end else begin
            units[n] = cp_acc[15:0];
            n = n + 1;
          end
          open_len = u2u16_pkg::SEQ_NONE;
          taken_cnt = 2'd0;
          cp_acc = 21'd0;
        end else if (l) begin
          for (int k = 0; k < taken_cnt; k++) begin
            units[n] = u2u16_pkg::REPL_CHAR;
            n = n + 1;
          end
          open_len = u2u16_pkg::SEQ_NONE;
          taken_cnt = 2'd0;
          cp_acc = 21'd0;
        end
        done = 1'b1;
      end else begin
        // broken sequence: one replacement per byte taken, then treat b as a lead
        for (int k = 0; k < taken_cnt; k++) begin
          units[n] = u2u16_pkg::REPL_CHAR;
          n = n + 1;
        end
        open_len = u2u16_pkg::SEQ_NONE;
        taken_cnt = 2'd0;
        cp_acc = 21'd0;
      end
    end
    if (!done) begin
      if (!b[7]) begin
        units[n] = {8'h00, b};
        n = n + 1;
      end else begin
        len = u2u16_pkg::SEQ_NONE;
        bits = 21'd0;
        if (b[7:5] == 3'b110) begin
          len = u2u16_pkg::SEQ_TWO;
          bits = {16'b0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          len = u2u16_pkg::SEQ_THREE;
          bits = {17'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          len = u2u16_pkg::SEQ_FOUR;
          bits = {18'b0, b[2:0]};
        end
        if (len == u2u16_pkg::SEQ_NONE || l) begin
          units[n] = u2u16_pkg::REPL_CHAR;
          n = n + 1;
        end else begin
          open_len = len;
          taken_cnt = 2'd1;
          cp_acc = bits;
        end
      end
    end
  endtask

  // offer one byte from a falling edge, wait for the beat, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic l, input bit calm,
                           input logic [1:0] typed_n, input logic [15:0] u0,
                           input logic [15:0] u1);
    u2u16_pkg::unit_vec_t units;
    int          n;
    int          gap;
    utf16_beat_t bt;
    logic [31:0] junk;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, l, units, n);
    if (typed_n != 2'd0) begin
      units = '0;
      units[0] = u0;
      units[1] = u1;
      n = int'(typed_n);
    end
    for (int i = 0; i < n; i++) begin
      bt.data = units[i][7:0];
      bt.last = 1'b0;
      utf16_beats_q = {utf16_beats_q, bt};
      bt.data = units[i][15:8];
      bt.last = (i == n - 1);
      utf16_beats_q = {utf16_beats_q, bt};
    end
    @(negedge clk);
    gap = idle_len(calm);
    if (gap > 0) begin
      junk = $urandom;
      s_tvalid <= 1'b0;
      s_tdata  <= junk[7:0];
      s_tlast  <= junk[8];
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    if (mismatch_cnt < 40)
      $display("mismatch at %0t ns, beat %0d: %s expected %02h got %02h",
               $time, beats_seen, what, exp_v, got_v);
    mismatch_cnt++;
  endtask

  // output checker
  always @(posedge clk) begin
    utf16_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (utf16_beats_q.size() == 0) begin
        report_mismatch("unexpected beat", 8'h00, m_tdata);
      end else begin
        want = utf16_beats_q.pop_front();
        if (m_tdata !== want.data) report_mismatch("out_byte", want.data, m_tdata);
        if (m_tlast !== want.last) report_mismatch("out_last", {7'b0, want.last}, {7'b0, m_tlast});
      end
      beats_seen <= beats_seen + 1;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output sink: random stalls, calm stretches, and long holds to back up the input
  initial begin : output_sink
    int stall_left;
    int rx_cycles;
    stall_left = 0;
    rx_cycles = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!stim_done && beats_seen >= next_hold_at) begin
        stall_left = HOLD_CYCLES - 1;
        next_hold_at = next_hold_at + 650;
        holds_done++;
        m_tready <= 1'b0;
      end else begin
        stall_left = idle_len((rx_cycles % 200) < 40);
        m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] seq[$];
    logic [7:0] nb;
    logic [31:0] rnd;
    int  kind;
    int  len;
    int  ncont;
    int  nchar;
    bit  calm;
    bit  fin;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].l, 1'b0, dir_rows[i].typed_n,
                dir_rows[i].u0, dir_rows[i].u1);
      dir_sent++;
    end

    // random strings: mostly well-formed characters, some truncated or junk bytes
    while (rand_sent < RAND_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      nchar = $urandom_range(1, 6);
      for (int c = 0; c < nchar; c++) begin
        seq.delete();
        kind = $urandom_range(0, 99);
        rnd = $urandom;
        if (kind < 20) begin
          nb = {1'b0, rnd[6:0]};
          seq = {seq, nb};
        end else if (kind < 88) begin
          if (kind < 40) len = 2;
          else if (kind < 60) len = 3;
          else if (kind < 78) len = 4;
          else len = $urandom_range(2, 4);
          ncont = (kind < 78) ? len - 1 : $urandom_range(0, len - 2);
          case (len)
            2: nb = {3'b110, rnd[4:0]};
            3: nb = {4'b1110, rnd[3:0]};
            default: nb = {5'b11110, rnd[2:0]};
          endcase
          seq = {seq, nb};
          for (int k = 0; k < ncont; k++) begin
            rnd = $urandom;
            nb = {2'b10, rnd[5:0]};
            seq = {seq, nb};
          end
        end else begin
          nb = rnd[7:0];
          seq = {seq, nb};
        end
        foreach (seq[i]) begin
          fin = (c == nchar - 1 && i == seq.size() - 1) || ($urandom_range(0, 39) == 0);
          send_byte(seq[i], fin, calm, 2'd0, 16'h0000, 16'h0000);
          rand_sent++;
        end
      end
      strings_sent++;
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;

    while (utf16_beats_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d directed and %0d random bytes in %0d strings, checked %0d output beats",
             dir_sent, rand_sent, strings_sent, beats_seen);
    $display("covered ascii, multibyte, surrogate pairs, bad and cut-off sequences, %0d hold(s)",
             holds_done);
    if (mismatch_cnt == 0 && utf16_beats_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d beats still expected", mismatch_cnt, utf16_beats_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/u2u16_pkg.sv
rtl/u2u16_decode.sv
rtl/u2u16_out.sv
rtl/utf8_to_utf16le_transcoder_core.sv
tb/sv/utf8_to_utf16le_transcoder_core_test.sv
